[design/assert_macros.svh]
// assertion helpers used by the f32f16_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that an implication holds on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// property that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[design/f32f16_pkg.sv]
package f32f16_pkg;
  localparam logic OP_S2H = 1'b0;
  localparam logic OP_H2S = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] bits;
  } f32f16_item_t;
endpackage

[design/f32f16_s2h.sv]
module f32f16_s2h (
  input  logic [31:0] x,
  output logic [15:0] h
);
  logic        sgn;
  logic [7:0]  e;
  logic [22:0] m;
  logic [4:0]  sh;
  logic [23:0] sig;
  logic [23:0] q;
  logic [23:0] rem;
  logic [23:0] hw;
  logic [23:0] msk;
  logic [30:0] full;
  logic [17:0] qn;
  logic        up;
  logic [7:0]  shw;

  always_comb begin
    sgn = x[31];
    e = x[30:23];
    m = x[22:0];
    full = {e - 8'd112, m};
    qn = full[30:13];
    up = full[12] && ((full[11:0] != 12'd0) || qn[0]);
    shw = 8'd126 - e;
    sh = shw[4:0];
    sig = {1'b1, m};
    q = sig >> sh;
    msk = (24'd1 << sh) - 24'd1;
    rem = sig & msk;
    hw = 24'd1 << (sh - 5'd1);
    h = {sgn, 15'd0};
    if (e == 8'hff) begin
      h = (m != 23'd0) ? {sgn, 5'h1f, 1'b1, m[21:13]} : {sgn, 15'h7c00};
    end else if (e == 8'd0) begin
      h = {sgn, 15'd0};
    end else if (e >= 8'd143) begin
      h = {sgn, 15'h7c00};
    end else if (e >= 8'd113) begin
      h = {sgn, 15'd0} | ((qn[15:0] + {15'd0, up}) & 16'h7fff);
    end else if (shw <= 8'd24) begin
      if (rem > hw || (rem == hw && q[0])) q = q + 24'd1;
      h = {sgn, q[14:0]};
    end
  end
endmodule

[design/f32f16_h2s.sv]
module f32f16_h2s (
  input  logic [15:0] h,
  output logic [31:0] s
);
  logic [4:0] e;
  logic [9:0] m;
  logic [3:0] p;
  logic [9:0] mn;

  always_comb begin
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = m << (4'd10 - p);
    if (e == 5'h1f) begin
      s = (m != 10'd0) ? {h[15], 8'hff, 1'b1, m[8:0], 13'd0} : {h[15], 8'hff, 23'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) s = {h[15], 31'd0};
      else s = {h[15], 8'({4'd0, p} + 8'd103), mn, 13'd0};
    end else begin
      s = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
  end
endmodule

[design/float32_float16_converter.sv]
// float32 / float16 format converter
// input channel: in_valid, in_stall, in_op, in_operand_bits
//   in_op 0 turns a binary32 pattern into binary16 (round to nearest even),
//   in_op 1 turns the binary16 pattern in bits 15..0 into binary32 (exact)
// output channel: out_valid, out_stall, out_result_bits
//   binary16 results sit in bits 15..0 with the upper bits zero
// an accepted transaction is latched in an input register, converted by
// one combinational pass, and stored in the result register
// out_valid rises once an accepted item has passed the input and result registers
// throughput: one transaction per cycle while out_stall is low, set by the single-pass datapath
// when out_stall is high a full result register and a full input register hold,
// in_stall rises only when both are full and the output is stalled
// reset (synchronous, active low) empties both registers
module float32_float16_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);
  import f32f16_pkg::*;

  f32f16_item_t item_r;
  logic         item_vld_r;
  logic [31:0]  res_r;
  logic         res_vld_r;
  logic [15:0]  half;
  logic [31:0]  single;
  logic [31:0]  res_nxt;
  logic         adv;

  f32f16_s2h u_s2h (.x(item_r.bits), .h(half));
  f32f16_h2s u_h2s (.h(item_r.bits[15:0]), .s(single));

  // result register frees up when empty or being taken
  assign adv      = !res_vld_r || !out_stall;
  assign in_stall = item_vld_r && !adv;
  assign res_nxt  = (item_r.op == OP_H2S) ? single : {16'd0, half};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (adv) res_vld_r <= item_vld_r;
      if (!in_stall) item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_vld_r) res_r <= res_nxt;
    if (!in_stall && in_valid) item_r <= '{op: in_op, bits: in_operand_bits};
  end

  assign out_valid       = res_vld_r;
  assign out_result_bits = res_r;
endmodule

[design/f32f16_checker.sv]
`include "assert_macros.svh"

module f32f16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic [31:0] in_operand_bits,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_bits
);
  // stalled result stays
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_bits))
  // stalled input transaction stays
  `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable({in_op, in_operand_bits}))
  // input stalls only when the output is backed up
  `CHK_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // accepted item while output is free: out_valid high once it passes input and result registers
  `CHK_NEXT(a_fill, clk, rst_n, in_valid && !in_stall && !out_stall, ##1 out_valid)
endmodule

bind float32_float16_converter f32f16_checker u_chk (.*);

[tb/float_conv_checker.sv]
`default_nettype none
module float_conv_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_operand_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result_bits,
  output int          fail_count,
  output int          pending_count
);
  import f32f16_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] expected_results[$];

  // round to nearest even of sig / 2^sh
  function automatic logic [31:0] rne_shift(logic [31:0] sig, int sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] halfway;
    q = sig >> sh;
    rem = sig & ((32'd1 << sh) - 32'd1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q = q + 32'd1;
    return q;
  endfunction

  function automatic logic [31:0] narrow_to_half(logic [31:0] x);
    logic [31:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    int          sh;
    sgn = {16'd0, x[31], 15'd0};
    e = x[30:23];
    m = x[22:0];
    if (e == 8'hff) begin
      if (m != 0) return sgn | 32'h7e00 | {22'd0, m[22:13]};
      return sgn | 32'h7c00;
    end
    if (e == 8'd0) return sgn;
    if (e >= 8'd143) return sgn | 32'h7c00;
    if (e >= 8'd113) return sgn | rne_shift({1'b0, e - 8'd112, m}, 13);
    sh = 126 - int'(e);
    if (sh > 24) return sgn;
    return sgn | rne_shift({9'd1, m}, sh);
  endfunction

  function automatic logic [31:0] widen_to_single(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    int          p;
    logic [31:0] mw;
    sgn = {h[15], 31'd0};
    e = h[14:10];
    m = h[9:0];
    if (e == 5'h1f) begin
      if (m != 0) return sgn | 32'h7fc00000 | ({22'd0, m} << 13);
      return sgn | 32'h7f800000;
    end
    if (e == 5'd0) begin
      if (m == 0) return sgn;
      p = 9;
      while (!m[p]) p--;
      mw = ({22'd0, m} << (23 - p)) & 32'h7fffff;
      return sgn | (32'(p + 103) << 23) | mw;
    end
    return sgn | (32'(e + 5'd0) + 32'd112) << 23 | ({22'd0, m} << 13);
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_op == OP_S2H) expected_results.push_back(narrow_to_half(in_operand_bits));
        else expected_results.push_back(widen_to_single(in_operand_bits[15:0]));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_result_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_result_bits) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", want, out_result_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[tb/tb_float32_float16_converter.sv]
`default_nettype none
module tb_float32_float16_converter;
  import f32f16_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_S2H;
  logic [31:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_bits;
  int          fail_count;
  int          pending_count;
  bit          hold_done = 1'b0;

  always #5 clk = ~clk;

  float32_float16_converter dut (.*);

  float_conv_checker checker_inst (.*);

  // directed operands: extremes, nan/inf, subnormals, rounding boundaries
  logic        dir_op[$];
  logic [31:0] dir_bits[$];

  task automatic add_case(logic op, logic [31:0] bits);
    dir_op.push_back(op);
    dir_bits.push_back(bits);
  endtask

  // random single: bias toward the exponent band where half is interesting
  function automatic logic [31:0] rand_single();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: x[30:23] = 8'($urandom_range(100, 145));
      3: x[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      4: x[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff; // near ties
      default: ;
    endcase
    return x;
  endfunction

  // one transaction, optional gap before it, waits for acceptance
  task automatic send_transaction(logic op, logic [31:0] bits, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_operand_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver: one long hold-off early, then random stalls
  initial begin
    int wait_cycles;
    wait (rst_n);
    @(posedge clk);
    out_stall <= 1'b1;
    repeat (60) @(posedge clk);
    hold_done = 1'b1;
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // timeout guard
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    add_case(OP_S2H, 32'h0000_0000); add_case(OP_S2H, 32'h8000_0000);
    add_case(OP_S2H, 32'h7f80_0000); add_case(OP_S2H, 32'hff80_0000);
    add_case(OP_S2H, 32'h7fc0_0001); add_case(OP_S2H, 32'hff80_2000);
    add_case(OP_S2H, 32'h0000_0001); add_case(OP_S2H, 32'h477f_e000);
    add_case(OP_S2H, 32'h477f_f000); add_case(OP_S2H, 32'hc780_0000);
    add_case(OP_S2H, 32'h3380_0000); add_case(OP_S2H, 32'h3380_0001);
    add_case(OP_S2H, 32'h3300_0000); add_case(OP_S2H, 32'h3f80_1000);
    add_case(OP_S2H, 32'h3f80_3000); add_case(OP_S2H, 32'hffff_ffff);
    add_case(OP_H2S, 32'hffff_0000); add_case(OP_H2S, 32'h0000_8000);
    add_case(OP_H2S, 32'h0000_0001); add_case(OP_H2S, 32'h0000_03ff);
    add_case(OP_H2S, 32'h0000_7c00); add_case(OP_H2S, 32'h1234_fc01);
    add_case(OP_H2S, 32'h0000_7bff); add_case(OP_H2S, 32'hffff_ffff);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // back-to-back so the long receiver hold-off fills the block
    foreach (dir_op[i]) send_transaction(dir_op[i], dir_bits[i], 1'b0);
    in_valid <= 1'b0;
    wait (hold_done);
    @(posedge clk);
    for (n = 0; n < 1800; n++) begin
      if ($urandom_range(0, 1)) send_transaction(OP_S2H, rand_single(), 1'b1);
      else send_transaction(OP_H2S, $urandom, 1'b1);
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+design
design/f32f16_pkg.sv
design/f32f16_s2h.sv
design/f32f16_h2s.sv
design/float32_float16_converter.sv
design/f32f16_checker.sv
tb/float_conv_checker.sv
tb/tb_float32_float16_converter.sv
